// ===== sv/sdrq_pkg.sv =====
package sdrq_pkg;

    localparam int KEY_W  = 31;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int MARK_W = 32;

    // Lowest/highest key reported when nothing is held
    localparam logic signed [MARK_W-1:0] EMPTY_MARK = 32'shFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_WR_NEW,
        S_POP_WAIT,
        S_POP_LOW,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    rd_mid;
        logic    search_step;
        logic    rd_head;
        logic    rd_second;
        logic    pop_capture;
        logic    pop_low;
        logic    pop_commit;
        logic    shift_init;
        logic    rd_shift;
        logic    wr_shift;
        logic    wr_new;
        logic    set_status;
        status_t status;
        logic    result_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic full;
        logic search_done;
        logic found;
        logic at_pos;
        logic pos_at_end;
        logic out_free;
        op_t  op;
    } dp_status_t;

endpackage

// ===== sv/sdrq_ram.sv =====
module sdrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/sdrq_ctrl.sv =====
module sdrq_ctrl
    import sdrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take a new transaction only when idle
    assign item_stall = (state_reg != S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_MISS;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_INSERT, OP_LOOKUP:
                    begin
                        state_next = S_SEARCH;
                    end
                    OP_POP:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_MISS;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_POP_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_MISS;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (!sts.search_done)
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_CMP;
                end
                else if (sts.op == OP_LOOKUP)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sts.found ? ST_OK : ST_MISS;
                    state_next     = S_DONE;
                end
                else if (sts.found)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DUP;
                    state_next     = S_DONE;
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                    state_next     = S_DONE;
                end
                else if (sts.pos_at_end)
                begin
                    state_next = S_WR_NEW;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SH_RD;
                end
            end
            S_CMP:
            begin
                cmd.search_step = 1'b1;
                state_next      = S_SEARCH;
            end
            S_SH_RD:
            begin
                cmd.rd_shift = 1'b1;
                state_next   = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = sts.at_pos ? S_WR_NEW : S_SH_RD;
            end
            S_WR_NEW:
            begin
                cmd.wr_new     = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end
            S_POP_WAIT:
            begin
                cmd.pop_capture = 1'b1;
                if (sts.count_one)
                begin
                    cmd.pop_commit = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_second = 1'b1;
                    state_next    = S_POP_LOW;
                end
            end
            S_POP_LOW:
            begin
                cmd.pop_low    = 1'b1;
                cmd.pop_commit = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sdrq_datapath.sv =====
module sdrq_datapath
    import sdrq_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         cmd,
    output dp_status_t                      sts,
    input  logic [OP_W-1:0]                 opcode,
    input  logic [KEY_W-1:0]                key,
    input  logic [PAYLOAD_BITS-1:0]         payload_ref,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [STAT_W-1:0]               status,
    output logic [KEY_W-1:0]                key_out,
    output logic [PAYLOAD_BITS-1:0]         payload_out,
    output logic signed [MARK_W-1:0]        lowest_key,
    output logic signed [MARK_W-1:0]        highest_key
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

    localparam logic [SUM_W-1:0]   CAP_S     = SUM_W'(CAPACITY);
    localparam logic [COUNT_W-1:0] CAP_C     = COUNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]   HEAD_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] ONE_C     = COUNT_W'(1);

    // Latched transaction
    logic [OP_W-1:0]         op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;

    // Queue bookkeeping: entries live at head .. head+count-1, wrapping
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [KEY_W-1:0]        low_key_reg, low_key_next;
    logic [KEY_W-1:0]        high_key_reg, high_key_next;

    // Search window and shift index
    logic [COUNT_W-1:0]      lo_reg, lo_next;
    logic [COUNT_W-1:0]      hi_reg, hi_next;
    logic [COUNT_W-1:0]      j_reg, j_next;
    logic                    found_reg, found_next;

    // Pending result
    logic [KEY_W-1:0]        kout_reg, kout_next;
    logic [PAYLOAD_BITS-1:0] pout_reg, pout_next;
    status_t                 status_reg, status_next;

    // Output register
    logic                    res_valid_reg, res_valid_next;
    status_t                 res_status_reg, res_status_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    logic signed [MARK_W-1:0] res_low_reg, res_low_next;
    logic signed [MARK_W-1:0] res_high_reg, res_high_next;

    // Memory port signals
    logic [COUNT_W:0]        mid_sum;
    logic [COUNT_W-1:0]      mid;
    logic [COUNT_W-1:0]      rd_idx;
    logic [COUNT_W-1:0]      wr_idx;
    logic                    rd_en;
    logic                    wr_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic [ENTRY_W-1:0]      rd_data;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    // Map a queue position to a memory slot
    function automatic logic [IDX_W-1:0] to_phys(
        input logic [IDX_W-1:0]   head_v,
        input logic [COUNT_W-1:0] idx
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(head_v) + SUM_W'(idx);
        if (s >= CAP_S)
        begin
            s = s - CAP_S;
        end
        return s[IDX_W-1:0];
    endfunction

    // Midpoint of the search window
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[COUNT_W:1];

    assign rd_key = rd_data[ENTRY_W-1:PAYLOAD_BITS];
    assign rd_pay = rd_data[PAYLOAD_BITS-1:0];

    // Select read position
    always_comb
    begin
        priority if (cmd.rd_head)
        begin
            rd_idx = '0;
        end
        else if (cmd.rd_second)
        begin
            rd_idx = ONE_C;
        end
        else if (cmd.rd_shift)
        begin
            rd_idx = j_reg;
        end
        else
        begin
            rd_idx = mid;
        end
    end

    assign rd_en   = cmd.rd_mid | cmd.rd_head | cmd.rd_second | cmd.rd_shift;
    assign rd_addr = to_phys(head_reg, rd_idx);

    // Move an entry up one place, or place the new entry
    assign wr_en   = cmd.wr_shift | cmd.wr_new;
    assign wr_idx  = cmd.wr_shift ? (j_reg + ONE_C) : lo_reg;
    assign wr_addr = to_phys(head_reg, wr_idx);
    assign wr_data = cmd.wr_shift ? rd_data : {key_reg, pay_reg};

    sdrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Status towards the controller
    always_comb
    begin
        sts.count_zero  = (count_reg == '0);
        sts.count_one   = (count_reg == ONE_C);
        sts.full        = (count_reg == CAP_C);
        sts.search_done = (lo_reg == hi_reg);
        sts.found       = found_reg;
        sts.at_pos      = (j_reg == lo_reg);
        sts.pos_at_end  = (lo_reg == count_reg);
        sts.out_free    = !res_valid_reg || !result_stall;
        sts.op          = op_t'(op_reg);
    end

    // Next-state logic
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        low_key_next    = low_key_reg;
        high_key_next   = high_key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        kout_next       = kout_reg;
        pout_next       = pout_reg;
        status_next     = status_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_low_next    = res_low_reg;
        res_high_next   = res_high_reg;

        // Drop the result once taken
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Latch the transaction and open the search window
        if (cmd.load_item)
        begin
            op_next    = opcode;
            key_next   = key;
            pay_next   = payload_ref;
            lo_next    = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
            kout_next  = '0;
            pout_next  = '0;
        end

        // Narrow the window on the probed key
        if (cmd.search_step)
        begin
            if (rd_key < key_reg)
            begin
                lo_next = mid + ONE_C;
            end
            else
            begin
                hi_next = mid;
            end
            if (rd_key == key_reg)
            begin
                found_next = 1'b1;
                if (op_reg == OP_LOOKUP)
                begin
                    kout_next = rd_key;
                    pout_next = rd_pay;
                end
            end
        end

        if (cmd.shift_init)
        begin
            j_next = count_reg - ONE_C;
        end

        if (cmd.wr_shift)
        begin
            j_next = j_reg - ONE_C;
        end

        // Commit an insert and track the extremes
        if (cmd.wr_new)
        begin
            count_next = count_reg + ONE_C;
            if (lo_reg == '0)
            begin
                low_key_next = key_reg;
            end
            if (lo_reg == count_reg)
            begin
                high_key_next = key_reg;
            end
        end

        if (cmd.pop_capture)
        begin
            kout_next = rd_key;
            pout_next = rd_pay;
        end

        if (cmd.pop_low)
        begin
            low_key_next = rd_key;
        end

        // Advance the head past the popped entry
        if (cmd.pop_commit)
        begin
            count_next = count_reg - ONE_C;
            head_next  = (head_reg == HEAD_LAST) ? '0 : (head_reg + IDX_W'(1));
        end

        if (cmd.set_status)
        begin
            status_next = cmd.status;
        end

        // Load the output register
        if (cmd.result_load)
        begin
            res_valid_next  = 1'b1;
            res_status_next = status_reg;
            res_key_next    = kout_reg;
            res_pay_next    = pout_reg;
            if (count_reg == '0)
            begin
                res_low_next  = EMPTY_MARK;
                res_high_next = EMPTY_MARK;
            end
            else
            begin
                res_low_next  = $signed({1'b0, low_key_reg});
                res_high_next = $signed({1'b0, high_key_reg});
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            j_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            j_reg         <= j_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        low_key_reg    <= low_key_next;
        high_key_reg   <= high_key_next;
        found_reg      <= found_next;
        kout_reg       <= kout_next;
        pout_reg       <= pout_next;
        status_reg     <= status_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_low_reg    <= res_low_next;
        res_high_reg   <= res_high_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign key_out      = res_key_reg;
    assign payload_out  = res_pay_reg;
    assign lowest_key   = res_low_reg;
    assign highest_key  = res_high_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count beyond capacity");

    a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> (count_reg != CAP_C))
        else $error("insert committed into a full queue");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> (j_reg >= lo_reg))
        else $error("shift below insert position");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> res_valid_reg)
        else $error("result loaded but not presented");
`endif

endmodule

// ===== sv/sorted_dedup_reorder_queue.sv =====
// Channel  | valid        | stall        | fields
// item     | item_valid   | item_stall   | opcode, key, payload_ref
// result   | result_valid | result_stall | status, key_out, payload_out,
//          |              |              | lowest_key, highest_key
//
// One transaction at a time. Pop when empty and unused opcodes go straight to the result;
// pop reads the head and, if more remain, the next entry as the new lowest key; lookup and
// insert make P probes (RAM read, compare), at most ceil(log2(n+1)) over n entries; unless
// refused, insert then moves M entries up (read, write) and writes the new one. The result
// waits in an output register while a new transaction is taken; a stalled result holds the
// controller before its next result. Asynchronous active-low reset empties the queue.
module sorted_dedup_reorder_queue
    import sdrq_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic [KEY_W-1:0]         key,
    input  logic [PAYLOAD_BITS-1:0]  payload_ref,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [STAT_W-1:0]        status,
    output logic [KEY_W-1:0]         key_out,
    output logic [PAYLOAD_BITS-1:0]  payload_out,
    output logic signed [MARK_W-1:0] lowest_key,
    output logic signed [MARK_W-1:0] highest_key
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    sdrq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    sdrq_datapath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .key          (key),
        .payload_ref  (payload_ref),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .key_out      (key_out),
        .payload_out  (payload_out),
        .lowest_key   (lowest_key),
        .highest_key  (highest_key)
    );

endmodule

// ===== tb/tb_sorted_dedup_reorder_queue.sv =====
`timescale 1ns / 100ps

module tb_sorted_dedup_reorder_queue;
    import sdrq_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int PAYLOAD_BITS  = 16;
    localparam int RANDOM_ITEMS  = 1030;
    localparam int ROUND_ITEMS   = 96;
    localparam int HOLD_RESULTS  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    // Opcode three has no meaning in the block; it must leave the queue alone
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX  = '1;
    localparam logic signed [MARK_W-1:0] MARK_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    typedef struct {
        status_t                  st;
        logic [KEY_W-1:0]         k;
        logic [PAYLOAD_BITS-1:0]  p;
        logic signed [MARK_W-1:0] lo;
        logic signed [MARK_W-1:0] hi;
    } reply_t;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [KEY_W-1:0]        k;
        logic [PAYLOAD_BITS-1:0] p;
        bit                      typed;
        reply_t                  want;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic [OP_W-1:0]          opcode;
    logic [KEY_W-1:0]         key;
    logic [PAYLOAD_BITS-1:0]  payload_ref;
    logic                     result_valid;
    logic                     result_stall;
    logic [STAT_W-1:0]        status;
    logic [KEY_W-1:0]         key_out;
    logic [PAYLOAD_BITS-1:0]  payload_out;
    logic signed [MARK_W-1:0] lowest_key;
    logic signed [MARK_W-1:0] highest_key;

    // Shadow copy of the sorted store
    logic [KEY_W-1:0]        held_keys [CAPACITY];
    logic [PAYLOAD_BITS-1:0] held_refs [CAPACITY];
    int                      held_count;

    reply_t pending_replies[$];
    row_t   directed_rows[$];
    int     mismatch_count;
    int     results_seen;
    int     idle_mode;
    bit     hold_active;

    sorted_dedup_reorder_queue #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .key          (key),
        .payload_ref  (payload_ref),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .key_out      (key_out),
        .payload_out  (payload_out),
        .lowest_key   (lowest_key),
        .highest_key  (highest_key)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Apply one command to the shadow store and work out its reply
    function automatic reply_t run_queue_command(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [PAYLOAD_BITS-1:0] p);
        reply_t r;
        int     pos;
        int     i;
        r.st = ST_MISS;
        r.k  = '0;
        r.p  = '0;
        pos  = 0;
        while (pos < held_count && held_keys[pos] < k)
            pos++;
        case (op)
            OP_INSERT:
            begin
                if (pos < held_count && held_keys[pos] == k)
                    r.st = ST_DUP;
                else if (held_count >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    for (i = held_count; i > pos; i--)
                    begin
                        held_keys[i] = held_keys[i-1];
                        held_refs[i] = held_refs[i-1];
                    end
                    held_keys[pos] = k;
                    held_refs[pos] = p;
                    held_count++;
                    r.st = ST_OK;
                end
            end
            OP_POP:
            begin
                if (held_count > 0)
                begin
                    r.k = held_keys[0];
                    r.p = held_refs[0];
                    for (i = 1; i < held_count; i++)
                    begin
                        held_keys[i-1] = held_keys[i];
                        held_refs[i-1] = held_refs[i];
                    end
                    held_count--;
                    r.st = ST_OK;
                end
            end
            OP_LOOKUP:
            begin
                if (pos < held_count && held_keys[pos] == k)
                begin
                    r.k  = k;
                    r.p  = held_refs[pos];
                    r.st = ST_OK;
                end
            end
            default: ;
        endcase
        if (held_count > 0)
        begin
            r.lo = {1'b0, held_keys[0]};
            r.hi = {1'b0, held_keys[held_count-1]};
        end
        else
        begin
            r.lo = EMPTY_MARK;
            r.hi = EMPTY_MARK;
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (hold_active || idle_mode == 0 || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return (idle_mode == 2) ? $urandom_range(10, 40) : $urandom_range(4, 12);
    endfunction

    // Key: held key now and then, else extremes, a narrow band or the full range
    function automatic logic [KEY_W-1:0] choose_key(input int held_pct);
        int roll;
        if (held_count > 0 && $urandom_range(0, 99) < held_pct)
            return held_keys[$urandom_range(0, held_count - 1)];
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return KEY_MAX;
        if (roll < 5)
            return KEY_W'($urandom_range(0, 200));
        return KEY_W'($urandom);
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op,
                           input logic [KEY_W-1:0] k,
                           input logic [PAYLOAD_BITS-1:0] p,
                           input bit typed = 1'b0,
                           input status_t st = ST_OK,
                           input logic [KEY_W-1:0] ko = '0,
                           input logic [PAYLOAD_BITS-1:0] po = '0,
                           input logic signed [MARK_W-1:0] lo = EMPTY_MARK,
                           input logic signed [MARK_W-1:0] hi = EMPTY_MARK);
        row_t row;
        row.op      = op;
        row.k       = k;
        row.p       = p;
        row.typed   = typed;
        row.want.st = st;
        row.want.k  = ko;
        row.want.p  = po;
        row.want.lo = lo;
        row.want.hi = hi;
        directed_rows.push_back(row);
    endtask

    // Offer one transaction, hold it until taken, then log the reply owed
    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic [KEY_W-1:0] k,
                                input logic [PAYLOAD_BITS-1:0] p,
                                input bit typed,
                                input reply_t want);
        int     gap;
        reply_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        opcode      <= op;
        key         <= k;
        payload_ref <= p;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pred = run_queue_command(op, k, p);
        pending_replies.push_back(typed ? want : pred);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got %h want %h", $time, results_seen, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        reply_t want;
        if (pending_replies.size() == 0)
            report_mismatch("unrequested result, status", 32'(status), 32'd0);
        else
        begin
            want = pending_replies.pop_front();
            if (status !== want.st)
                report_mismatch("status", 32'(status), 32'(want.st));
            if (key_out !== want.k)
                report_mismatch("key_out", 32'(key_out), 32'(want.k));
            if (payload_out !== want.p)
                report_mismatch("payload_out", 32'(payload_out), 32'(want.p));
            if (lowest_key !== want.lo)
                report_mismatch("lowest_key", lowest_key, want.lo);
            if (highest_key !== want.hi)
                report_mismatch("highest_key", highest_key, want.hi);
        end
        results_seen++;
    endtask

    // Result side: check, then idle at random; hold off once for a long stretch
    initial
    begin : result_side
        int stall_left;
        bit hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                check_result();
                stall_left = pick_gap();
            end
            if (!hold_done && results_seen >= HOLD_RESULTS)
            begin
                hold_done   = 1'b1;
                hold_active = 1'b1;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                hold_active = 1'b0;
            end
        end
    end

    // Abort when neither channel moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : item_side
        int               n;
        int               roll;
        int               ins_pct;
        int               pop_pct;
        int               look_pct;
        mix_t             mix;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        reply_t           none;

        mismatch_count = 0;
        results_seen   = 0;
        held_count     = 0;
        hold_active    = 1'b0;
        idle_mode      = 1;
        none.st        = ST_OK;
        none.k         = '0;
        none.p         = '0;
        none.lo        = EMPTY_MARK;
        none.hi        = EMPTY_MARK;
        rst_n          <= 1'b0;
        item_valid     <= 1'b0;
        opcode         <= '0;
        key            <= '0;
        payload_ref    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, extremes, duplicates, misses, unused opcode, drain to empty
        add_row(OP_POP,    '0,      '0,      1'b1, ST_MISS);
        add_row(OP_LOOKUP, '0,      '0,      1'b1, ST_MISS);
        add_row(OP_UNUSED, KEY_MAX, '1,      1'b1, ST_MISS);
        add_row(OP_INSERT, KEY_MAX, '1,      1'b1, ST_OK, '0, '0, MARK_MAX, MARK_MAX);
        add_row(OP_INSERT, '0,      '0,      1'b1, ST_OK, '0, '0, '0, MARK_MAX);
        add_row(OP_INSERT, KEY_MAX, 16'h1234, 1'b1, ST_DUP, '0, '0, '0, MARK_MAX);
        add_row(OP_LOOKUP, KEY_MAX, '0,      1'b1, ST_OK, KEY_MAX, '1, '0, MARK_MAX);
        add_row(OP_LOOKUP, '0,      '1,      1'b1, ST_OK, '0, '0, '0, MARK_MAX);
        add_row(OP_LOOKUP, 31'd1,   '0,      1'b1, ST_MISS, '0, '0, '0, MARK_MAX);
        add_row(OP_INSERT, 31'h2AAA_AAAA, 16'h5555);
        add_row(OP_INSERT, 31'h5555_5555, 16'hAAAA);
        add_row(OP_INSERT, 31'd1,   16'h0001);
        add_row(OP_UNUSED, 31'd1,   16'h00FF, 1'b1, ST_MISS, '0, '0, '0, MARK_MAX);
        add_row(OP_LOOKUP, 31'h5555_5555, '0);
        add_row(OP_LOOKUP, 31'h2AAA_AAAB, '0);
        add_row(OP_POP,    '0,      '0);
        add_row(OP_POP,    KEY_MAX, '1);
        add_row(OP_POP,    '0,      '0);
        add_row(OP_POP,    '0,      '0);
        add_row(OP_POP,    '0,      '0);
        add_row(OP_POP,    '0,      '0,      1'b1, ST_MISS);
        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].k, directed_rows[i].p,
                         directed_rows[i].typed, directed_rows[i].want);

        // Rounds weighted in turn towards filling, towards draining, and towards churn
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % ROUND_ITEMS == 0)
            begin
                mix       = mix_t'((n / ROUND_ITEMS) % 3);
                idle_mode = $urandom_range(0, 2);
            end
            case (mix)
                MIX_FILL:  begin ins_pct = 80; pop_pct = 8;  look_pct = 10; end
                MIX_DRAIN: begin ins_pct = 12; pop_pct = 75; look_pct = 10; end
                default:   begin ins_pct = 40; pop_pct = 30; look_pct = 27; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
            begin
                op = OP_INSERT;
                k  = choose_key(20);
            end
            else if (roll < ins_pct + pop_pct)
            begin
                op = OP_POP;
                k  = KEY_W'($urandom);
            end
            else if (roll < ins_pct + pop_pct + look_pct)
            begin
                op = OP_LOOKUP;
                k  = choose_key(60);
            end
            else
            begin
                op = OP_UNUSED;
                k  = KEY_W'($urandom);
            end
            send_command(op, k, PAYLOAD_BITS'($urandom), 1'b0, none);
        end
        item_valid <= 1'b0;

        // Wait for every reply owed, then let the block settle
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sorted_dedup_reorder_queue.f =====
sv/sdrq_pkg.sv
sv/sdrq_ram.sv
sv/sdrq_ctrl.sv
sv/sdrq_datapath.sv
sv/sorted_dedup_reorder_queue.sv
tb/tb_sorted_dedup_reorder_queue.sv
